### design/ppts_pkg.sv
`default_nettype none
package ppts_pkg;
    localparam int COEFFS_PER_AXIS = 8;
    localparam int SEGMENT_COUNT = 32;
    localparam int AXES = 3;
    localparam int CW = $clog2(COEFFS_PER_AXIS);
    localparam int SW = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;
    localparam int STORE_DEPTH = SEGMENT_COUNT * AXES * COEFFS_PER_AXIS;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int QDEPTH = 4;
    localparam int QW = $clog2(QDEPTH);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic [SW-1:0] segment;
        logic          in_range;
        logic [23:0]   sample_time;
    } eval_cmd_t;

    typedef struct packed {
        logic [1:0]  out_axis;
        logic [31:0] position;
        logic [31:0] velocity;
        logic [31:0] acceleration;
        logic        saturated;
        logic        last;
    } result_t;

    // Address of coefficient j of an axis within a segment.
    function automatic logic [AW-1:0] coeff_addr(input logic [SW-1:0] seg,
                                                 input logic [1:0] ax,
                                                 input logic [CW-1:0] j);
        logic [AW+3:0] a;
        a = ((AW+4)'(seg) * (AW+4)'(AXES) + (AW+4)'(ax)) * (AW+4)'(COEFFS_PER_AXIS)
            + (AW+4)'(j);
        return a[AW-1:0];
    endfunction
endpackage
`default_nettype wire

### design/ppts_ram.sv
`default_nettype none
module ppts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

### design/ppts_front.sv
`default_nettype none
module ppts_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [66:0]               in_data,
    output logic                           wr_en,
    output logic [ppts_pkg::AW-1:0]        wr_addr,
    output logic [31:0]                    wr_data,
    output logic                           q_valid,
    input  wire logic                      q_pop,
    output ppts_pkg::eval_cmd_t            q_head
);
    logic                  op;
    logic [4:0]            seg;
    logic [1:0]            ax;
    logic [2:0]            ci;
    logic [31:0]           cval;
    logic [23:0]           tval;
    logic                  seg_ok;
    logic                  accept;
    logic                  push;
    ppts_pkg::eval_cmd_t   q_mem [ppts_pkg::QDEPTH];
    logic [ppts_pkg::QW-1:0] wp_reg, rp_reg;
    logic [ppts_pkg::QW:0]   cnt_reg;

    assign op   = in_data[0];
    assign seg  = in_data[5:1];
    assign ax   = in_data[7:6];
    assign ci   = in_data[10:8];
    assign cval = in_data[42:11];
    assign tval = in_data[66:43];

    assign seg_ok = 32'(seg) < ppts_pkg::SEGMENT_COUNT;
    // A write waits until every queued evaluation has finished reading the store,
    // so it never changes coefficients that an earlier word still needs.
    assign in_ready = (cnt_reg != (ppts_pkg::QW+1)'(ppts_pkg::QDEPTH))
                      && ((op == ppts_pkg::OP_EVAL) || (cnt_reg == '0));
    assign accept = in_valid && in_ready;
    assign push = accept && (op == ppts_pkg::OP_EVAL);

    // Writes outside the store are dropped here.
    assign wr_en = accept && (op == ppts_pkg::OP_WRITE) && seg_ok && (ax != 2'd3)
                   && (32'(ci) < ppts_pkg::COEFFS_PER_AXIS);
    assign wr_addr = ppts_pkg::coeff_addr(ppts_pkg::SW'(seg), ax, ppts_pkg::CW'(ci));
    assign wr_data = cval;

    assign q_valid = cnt_reg != '0;
    assign q_head = q_mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wp_reg] <= '{segment: ppts_pkg::SW'(seg), in_range: seg_ok,
                               sample_time: tval};
        end
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (q_pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (ppts_pkg::QW+1)'(push) - (ppts_pkg::QW+1)'(q_pop);
        end
    end
endmodule
`default_nettype wire

### design/ppts_back.sv
`default_nettype none
module ppts_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    output logic                      q_pop,
    input  ppts_pkg::eval_cmd_t       q_head,
    output logic [ppts_pkg::AW-1:0]   rd_addr,
    input  wire logic [31:0]          rd_data,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output ppts_pkg::result_t         res
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_MUL   = 5'b00100,
        S_ADD   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t                state_reg;
    logic [1:0]            axis_reg;
    logic [ppts_pkg::CW:0] j_reg;
    logic                  wait_reg;
    logic signed [31:0]    acc_reg [3];
    logic signed [31:0]    coef_reg;
    logic signed [56:0]    prod_reg [3];
    logic                  sat_reg;
    logic                  outv_reg;
    ppts_pkg::result_t     res_reg;

    logic [ppts_pkg::CW-1:0] jj;
    logic signed [40:0]    w [3];
    logic signed [57:0]    sum;
    logic signed [41:0]    tot;
    logic [2:0]            en;
    logic signed [31:0]    clamped [3];
    logic [2:0]            clip;

    assign jj = j_reg[ppts_pkg::CW-1:0];
    assign rd_addr = ppts_pkg::coeff_addr(q_head.segment, axis_reg, jj);
    assign q_pop = (state_reg == S_OUT) && !outv_reg && (axis_reg == 2'd2);
    assign res_valid = outv_reg;
    assign res = res_reg;

    always_comb begin
        w[0] = 41'(coef_reg);
        w[1] = 41'(coef_reg) * 41'($signed({1'b0, j_reg}));
        w[2] = w[1] * 41'($signed({1'b0, j_reg - 1'b1}));
        en[0] = 1'b1;
        en[1] = j_reg >= 1;
        en[2] = j_reg >= 2;
        for (int k = 0; k < 3; k++) begin
            sum = 58'(prod_reg[k]) + 58'sd32768;
            tot = 42'(sum >>> 16) + 42'(w[k]);
            clip[k] = 1'b0;
            if (tot > 42'sd2147483647) begin
                clamped[k] = 32'sh7fffffff;
                clip[k] = en[k];
            end else if (tot < -42'sd2147483648) begin
                clamped[k] = 32'sh80000000;
                clip[k] = en[k];
            end else begin
                clamped[k] = tot[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            outv_reg <= 1'b0;
            axis_reg <= '0;
            j_reg <= '0;
            wait_reg <= 1'b0;
        end else begin
            if (outv_reg && res_ready) outv_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        axis_reg <= '0;
                        j_reg <= (ppts_pkg::CW+1)'(ppts_pkg::COEFFS_PER_AXIS - 1);
                        for (int k = 0; k < 3; k++) acc_reg[k] <= '0;
                        sat_reg <= 1'b0;
                        wait_reg <= 1'b1;
                        state_reg <= q_head.in_range ? S_FETCH : S_OUT;
                    end
                end
                S_FETCH: begin
                    // Wait out the registered memory read.
                    wait_reg <= 1'b0;
                    if (!wait_reg) begin
                        coef_reg <= rd_data;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    for (int k = 0; k < 3; k++) begin
                        prod_reg[k] <= 57'(acc_reg[k]) * 57'($signed({1'b0,
                                       q_head.sample_time}));
                    end
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    for (int k = 0; k < 3; k++) begin
                        if (en[k]) acc_reg[k] <= clamped[k];
                    end
                    sat_reg <= sat_reg | (|clip);
                    if (j_reg == '0) begin
                        state_reg <= S_OUT;
                    end else begin
                        j_reg <= j_reg - 1'b1;
                        wait_reg <= 1'b1;
                        state_reg <= S_FETCH;
                    end
                end
                S_OUT: begin
                    if (!outv_reg) begin
                        res_reg <= '{out_axis: axis_reg,
                                     position: q_head.in_range ? acc_reg[0] : '0,
                                     velocity: q_head.in_range ? acc_reg[1] : '0,
                                     acceleration: q_head.in_range ? acc_reg[2] : '0,
                                     saturated: q_head.in_range && sat_reg,
                                     last: axis_reg == 2'd2};
                        outv_reg <= 1'b1;
                        if (axis_reg == 2'd2) begin
                            state_reg <= S_IDLE;
                        end else begin
                            axis_reg <= axis_reg + 1'b1;
                            j_reg <= (ppts_pkg::CW+1)'(ppts_pkg::COEFFS_PER_AXIS - 1);
                            for (int k = 0; k < 3; k++) acc_reg[k] <= '0;
                            sat_reg <= 1'b0;
                            wait_reg <= 1'b1;
                            state_reg <= q_head.in_range ? S_FETCH : S_OUT;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### design/piecewise_poly_trajectory_sampler.sv
// Piecewise polynomial trajectory sampler.
// Input stream s_*: each word either writes one coefficient (operation 0) into
// the coefficient memory or asks for an evaluation (operation 1) of a segment
// at a local time. A write yields nothing; it is held off while any evaluation
// is queued or running, so it never overtakes an earlier evaluation.
// Output stream m_*: each evaluation yields three words, x, y and z, with
// position, velocity and acceleration; tlast marks the z word.
// The front accepts evaluations into a four-entry command queue; the back
// walks the coefficients with one shared set of three multiply and accumulate
// units, taking each coefficient through address, read, multiply and add
// steps, eight coefficients per axis and one evaluation at a time.
// When the receiver stalls, the output register holds its word and the back
// waits; the front keeps accepting evaluations until the queue is full.
// Reset empties the queue and the output; the memory contents are kept and
// must be written before being evaluated.
`default_nettype none
module piecewise_poly_trajectory_sampler (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // operation, segment, axis, coeff_index, coeff_value, sample_time, zero pad
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_axis, position, velocity, acceleration, saturated, zero pad
    output logic [103:0]     m_tdata,
    output logic             m_tlast
);
    logic                    wr_en;
    logic [ppts_pkg::AW-1:0] wr_addr, rd_addr;
    logic [31:0]             wr_data, rd_data;
    logic                    q_valid, q_pop;
    ppts_pkg::eval_cmd_t     q_head;
    ppts_pkg::result_t       res;

    ppts_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata[66:0]),
        .wr_en, .wr_addr, .wr_data,
        .q_valid, .q_pop, .q_head
    );

    ppts_ram #(.WIDTH(32), .DEPTH(ppts_pkg::STORE_DEPTH)) u_ram (
        .aclk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
    );

    ppts_back u_back (
        .aclk, .aresetn,
        .q_valid, .q_pop, .q_head, .rd_addr, .rd_data,
        .res_valid(m_tvalid), .res_ready(m_tready), .res
    );

    assign m_tdata = {5'd0, res.saturated, res.acceleration, res.velocity,
                      res.position, res.out_axis};
    assign m_tlast = res.last;

    a_last_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[1:0] == 2'd2)))
        else $error("tlast does not match z axis");
    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("bad result axis");
    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");
endmodule
`default_nettype wire
